// File: design/nre_pkg.sv
// Shared types, constants and helpers for the nearest ridge elevation block.
package nre_pkg;

	localparam logic [31:0] TOL_RAW = 32'd66;
	localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_POST,
		ST_WAIT,
		ST_CHECK,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_AXX,
		OP_AYY,
		OP_BXX,
		OP_BYY,
		OP_DXX,
		OP_DYY,
		OP_DOTA,
		OP_DOTB,
		OP_CRSA,
		OP_CRSB,
		OP_RADA,
		OP_RADB,
		OP_PROD
	} op_t;

	typedef enum logic [1:0] {
		K_SINGLE,
		K_END,
		K_INT
	} kind_t;

	typedef enum logic {
		M_SQRT,
		M_DIV
	} iter_mode_t;

	typedef struct packed {
		logic        start;
		iter_mode_t  mode;
		logic [63:0] num;
		logic [31:0] den;
	} iter_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} iter_rsp_t;

	function automatic logic [31:0] mag33(input logic [32:0] v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

endpackage

// File: design/nre_mul.sv
// Registered 32x32 unsigned multiplier shared by all products.
module nre_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= 64'(a) * 64'(b);
	end

endmodule

// File: design/nre_iter.sv
// Iterative unit: 64-bit integer square root or 64/32 restoring division.
module nre_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  nre_pkg::iter_req_t  req,
	output nre_pkg::iter_rsp_t  rsp
);

	logic                busy_q;
	logic                done_q;
	logic [5:0]          cnt_q;
	nre_pkg::iter_mode_t mode_q;
	logic [63:0]         x_q;
	logic [63:0]         r_q;
	logic [63:0]         bit_q;
	logic [32:0]         rem_q;
	logic [31:0]         den_q;

	logic [63:0] trial;
	logic        sq_ge;
	logic [32:0] rs;
	logic        dv_ge;
	logic        last_step;

	always_comb begin
		trial     = r_q + bit_q;
		sq_ge     = x_q >= trial;
		rs        = {rem_q[31:0], x_q[63]};
		dv_ge     = rs >= {1'b0, den_q};
		last_step = (mode_q == nre_pkg::M_SQRT) ? (cnt_q == 6'd31) : (cnt_q == 6'd63);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= nre_pkg::M_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				mode_q <= req.mode;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.num;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (mode_q == nre_pkg::M_SQRT) begin
				if (sq_ge) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q <= dv_ge ? (rs - {1'b0, den_q}) : rs;
				x_q   <= {x_q[62:0], dv_ge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (mode_q == nre_pkg::M_SQRT) ? r_q : x_q;

endmodule

// File: design/nearest_ridge_elevation_core.sv
// Top level: nearest ridge distance and elevation for one query point.
//
// Input channel s_*: one ridge per transaction. s_tdata carries the query
// point, both endpoints and their elevations; s_tuser flags a single-point
// ridge; s_tlast marks the final ridge of the query point.
// Output channel m_*: one transaction per s_tlast ridge with the nearest
// distance and elevation; m_tuser is the found flag.
// Each ridge runs through one registered 32x32 multiplier and one iterative
// root/divide unit under a sequencer; s_tready is high only when idle.
// Cost per ridge is set by the iterative unit plus the products: one root
// for a single point, up to three roots for an endpoint case, and for an
// interior projection up to three roots, a cross divide, a radicand root
// and an elevation divide.
// The result register frees the core once loaded; if m_tready stays low and
// a new last ridge finishes, the core holds until the register drains.
// Reset clears the kept ridge, the sequencer and the output valid.
module nearest_ridge_elevation_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, end0_x, end0_y, end0_elev, end1_x, end1_y, end1_elev
	input  logic [255:0] s_tdata,
	// single_point
	input  logic         s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// nearest_dist, nearest_elev
	output logic [63:0]  m_tdata,
	// found
	output logic         m_tuser
);

	nre_pkg::state_t state_q, state_d;
	nre_pkg::op_t    op_q;
	nre_pkg::kind_t  kind_q;
	nre_pkg::iter_req_t req;
	nre_pkg::iter_rsp_t rsp;

	logic signed [32:0] ax, ay, bx, by, dx, dy, df;

	logic [31:0] ax_m_q, ay_m_q, bx_m_q, by_m_q, dx_m_q, dy_m_q, df_m_q;
	logic        ax_n_q, ay_n_q, dx_n_q, dy_n_q, df_n_q;
	logic [31:0] e0_q, e1_q;
	logic        single_q, last_q;
	logic [31:0] d0_q, d1_q, seg_q, dist_q, p_q;
	logic [31:0] elev_q;
	logic        ovf_q;
	logic signed [66:0] acc_q, den_q;

	logic [31:0] best_dist_q, best_elev_q;
	logic        have_q;
	logic        m_valid_q;
	logic [31:0] out_dist_q, out_elev_q;
	logic        out_found_q;

	logic [31:0] mul_a, mul_b;
	logic        mul_neg, mul_clr;
	logic        neg_s1, clr_s1;
	logic [63:0] p_s1;
	logic signed [66:0] pe, acc_next, cmag;
	logic [31:0] root_sat, div_sat, seg_div;
	logic        degen, skip, out_free, pair_first;
	logic [32:0] q33;
	logic signed [34:0] v35;
	logic [31:0] elev_int;

	always_comb begin
		ax = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({s_tdata[95], s_tdata[95:64]});
		ay = $signed({s_tdata[63], s_tdata[63:32]}) - $signed({s_tdata[127], s_tdata[127:96]});
		bx = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({s_tdata[191], s_tdata[191:160]});
		by = $signed({s_tdata[63], s_tdata[63:32]}) - $signed({s_tdata[223], s_tdata[223:192]});
		dx = $signed({s_tdata[191], s_tdata[191:160]}) - $signed({s_tdata[95], s_tdata[95:64]});
		dy = $signed({s_tdata[223], s_tdata[223:192]}) - $signed({s_tdata[127], s_tdata[127:96]});
		df = $signed({s_tdata[255], s_tdata[255:224]}) - $signed({s_tdata[159], s_tdata[159:128]});
	end

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		mul_clr = 1'b1;
		case (op_q)
			nre_pkg::OP_AXX: begin mul_a = ax_m_q; mul_b = ax_m_q; end
			nre_pkg::OP_AYY: begin mul_a = ay_m_q; mul_b = ay_m_q; mul_clr = 1'b0; end
			nre_pkg::OP_BXX: begin mul_a = bx_m_q; mul_b = bx_m_q; end
			nre_pkg::OP_BYY: begin mul_a = by_m_q; mul_b = by_m_q; mul_clr = 1'b0; end
			nre_pkg::OP_DXX: begin mul_a = dx_m_q; mul_b = dx_m_q; end
			nre_pkg::OP_DYY: begin mul_a = dy_m_q; mul_b = dy_m_q; mul_clr = 1'b0; end
			nre_pkg::OP_DOTA: begin
				mul_a = ax_m_q; mul_b = dx_m_q; mul_neg = ax_n_q ^ dx_n_q;
			end
			nre_pkg::OP_DOTB: begin
				mul_a = ay_m_q; mul_b = dy_m_q; mul_neg = ay_n_q ^ dy_n_q; mul_clr = 1'b0;
			end
			nre_pkg::OP_CRSA: begin
				mul_a = ax_m_q; mul_b = dy_m_q; mul_neg = ax_n_q ^ dy_n_q;
			end
			nre_pkg::OP_CRSB: begin
				mul_a = ay_m_q; mul_b = dx_m_q; mul_neg = ~(ay_n_q ^ dx_n_q); mul_clr = 1'b0;
			end
			nre_pkg::OP_RADA: begin mul_a = d0_q; mul_b = d0_q; end
			nre_pkg::OP_RADB: begin
				mul_a = dist_q; mul_b = dist_q; mul_neg = 1'b1; mul_clr = 1'b0;
			end
			nre_pkg::OP_PROD: begin mul_a = p_q; mul_b = df_m_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	nre_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (p_s1)
	);

	nre_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk) begin
		neg_s1 <= mul_neg;
		clr_s1 <= mul_clr;
	end

	always_comb begin
		pe         = $signed({3'b000, p_s1});
		acc_next   = (clr_s1 ? 67'sd0 : acc_q) + (neg_s1 ? -pe : pe);
		cmag       = acc_q[66] ? -acc_q : acc_q;
		root_sat   = ovf_q ? nre_pkg::MAX32 : rsp.res[31:0];
		div_sat    = (rsp.res[63:32] != 32'd0) ? nre_pkg::MAX32 : rsp.res[31:0];
		seg_div    = (seg_q == 32'd0) ? 32'd1 : seg_q;
		degen      = (dx_m_q < nre_pkg::TOL_RAW) && (dy_m_q < nre_pkg::TOL_RAW);
		skip       = have_q && (best_dist_q < dist_q);
		out_free   = !m_valid_q || m_tready;
		pair_first = (op_q == nre_pkg::OP_AXX) || (op_q == nre_pkg::OP_BXX) ||
			(op_q == nre_pkg::OP_DXX) || (op_q == nre_pkg::OP_DOTA) ||
			(op_q == nre_pkg::OP_CRSA) || (op_q == nre_pkg::OP_RADA);
		q33        = (rsp.res[63:33] != 31'd0) ? 33'h1_FFFF_FFFF : rsp.res[32:0];
		v35        = df_n_q ? ($signed({{3{e0_q[31]}}, e0_q}) - $signed({2'b00, q33}))
			: ($signed({{3{e0_q[31]}}, e0_q}) + $signed({2'b00, q33}));
		if (v35 > 35'sh0_7FFF_FFFF)
			elev_int = 32'h7FFF_FFFF;
		else if (v35 < -35'sh0_8000_0000)
			elev_int = 32'h8000_0000;
		else
			elev_int = v35[31:0];
	end

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.mode  = nre_pkg::M_SQRT;
		req.num   = acc_q[63:0];
		req.den   = seg_div;
		case (state_q)
			nre_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = nre_pkg::ST_MUL;
			end
			nre_pkg::ST_MUL: state_d = nre_pkg::ST_ACC;
			nre_pkg::ST_ACC: begin
				state_d = pair_first ? nre_pkg::ST_MUL : nre_pkg::ST_POST;
				if (op_q == nre_pkg::OP_PROD) state_d = nre_pkg::ST_POST;
			end
			nre_pkg::ST_POST: begin
				case (op_q)
					nre_pkg::OP_AYY, nre_pkg::OP_BYY, nre_pkg::OP_DYY: begin
						req.start = 1'b1;
						state_d   = nre_pkg::ST_WAIT;
					end
					nre_pkg::OP_DOTB: begin
						if (acc_q < 67'sd0 || acc_q > den_q)
							state_d = nre_pkg::ST_UPDATE;
						else
							state_d = nre_pkg::ST_MUL;
					end
					nre_pkg::OP_CRSB: begin
						if (cmag[66:64] != 3'd0) begin
							state_d = nre_pkg::ST_CHECK;
						end else begin
							req.start = 1'b1;
							req.mode  = nre_pkg::M_DIV;
							req.num   = cmag[63:0];
							state_d   = nre_pkg::ST_WAIT;
						end
					end
					nre_pkg::OP_RADB: begin
						if (acc_q < 67'sd0) begin
							state_d = nre_pkg::ST_UPDATE;
						end else begin
							req.start = 1'b1;
							state_d   = nre_pkg::ST_WAIT;
						end
					end
					nre_pkg::OP_PROD: begin
						req.start = 1'b1;
						req.mode  = nre_pkg::M_DIV;
						state_d   = nre_pkg::ST_WAIT;
					end
					default: state_d = nre_pkg::ST_IDLE;
				endcase
			end
			nre_pkg::ST_WAIT: begin
				if (rsp.done) begin
					case (op_q)
						nre_pkg::OP_AYY:
							state_d = single_q ? nre_pkg::ST_UPDATE : nre_pkg::ST_MUL;
						nre_pkg::OP_BYY:
							state_d = degen ? nre_pkg::ST_UPDATE : nre_pkg::ST_MUL;
						nre_pkg::OP_DYY:  state_d = nre_pkg::ST_MUL;
						nre_pkg::OP_CRSB: state_d = nre_pkg::ST_CHECK;
						nre_pkg::OP_RADB: state_d = nre_pkg::ST_MUL;
						nre_pkg::OP_PROD: state_d = nre_pkg::ST_UPDATE;
						default:          state_d = nre_pkg::ST_IDLE;
					endcase
				end
			end
			nre_pkg::ST_CHECK: state_d = skip ? nre_pkg::ST_FINISH : nre_pkg::ST_MUL;
			nre_pkg::ST_UPDATE: state_d = nre_pkg::ST_FINISH;
			nre_pkg::ST_FINISH: begin
				if (!last_q || out_free) state_d = nre_pkg::ST_IDLE;
			end
			default: state_d = nre_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nre_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= nre_pkg::OP_AXX;
			kind_q      <= nre_pkg::K_SINGLE;
			best_dist_q <= '0;
			best_elev_q <= '0;
			have_q      <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (m_tready && !(state_q == nre_pkg::ST_FINISH && last_q && out_free))
				m_valid_q <= 1'b0;
			case (state_q)
				nre_pkg::ST_IDLE: begin
					if (s_tvalid) op_q <= nre_pkg::OP_AXX;
				end
				nre_pkg::ST_ACC: begin
					if (pair_first) op_q <= nre_pkg::op_t'(op_q + 4'd1);
				end
				nre_pkg::ST_POST: begin
					case (op_q)
						nre_pkg::OP_DOTB: begin
							if (acc_q < 67'sd0 || acc_q > den_q)
								kind_q <= nre_pkg::K_END;
							else
								op_q <= nre_pkg::OP_CRSA;
						end
						nre_pkg::OP_RADB: begin
							if (acc_q < 67'sd0) kind_q <= nre_pkg::K_INT;
						end
						default: ;
					endcase
				end
				nre_pkg::ST_WAIT: begin
					if (rsp.done) begin
						case (op_q)
							nre_pkg::OP_AYY: begin
								if (single_q)
									kind_q <= nre_pkg::K_SINGLE;
								else
									op_q <= nre_pkg::OP_BXX;
							end
							nre_pkg::OP_BYY: begin
								if (degen)
									kind_q <= nre_pkg::K_END;
								else
									op_q <= nre_pkg::OP_DXX;
							end
							nre_pkg::OP_DYY:  op_q <= nre_pkg::OP_DOTA;
							nre_pkg::OP_RADB: op_q <= nre_pkg::OP_PROD;
							nre_pkg::OP_PROD: kind_q <= nre_pkg::K_INT;
							default: ;
						endcase
					end
				end
				nre_pkg::ST_CHECK: begin
					if (!skip) op_q <= nre_pkg::OP_RADA;
				end
				nre_pkg::ST_UPDATE: begin
					case (kind_q)
						nre_pkg::K_SINGLE: begin
							if (!have_q || d0_q < best_dist_q) begin
								best_dist_q <= d0_q;
								best_elev_q <= e0_q;
							end
						end
						nre_pkg::K_END: begin
							if (!skip) begin
								if (d0_q < d1_q) begin
									best_dist_q <= d0_q;
									best_elev_q <= e0_q;
								end else begin
									best_dist_q <= d1_q;
									best_elev_q <= e1_q;
								end
							end
						end
						nre_pkg::K_INT: begin
							best_dist_q <= dist_q;
							best_elev_q <= elev_q;
						end
						default: ;
					endcase
					have_q <= 1'b1;
				end
				nre_pkg::ST_FINISH: begin
					if (last_q && out_free) begin
						m_valid_q   <= 1'b1;
						best_dist_q <= '0;
						best_elev_q <= '0;
						have_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nre_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					ax_m_q   <= nre_pkg::mag33(ax);
					ay_m_q   <= nre_pkg::mag33(ay);
					bx_m_q   <= nre_pkg::mag33(bx);
					by_m_q   <= nre_pkg::mag33(by);
					dx_m_q   <= nre_pkg::mag33(dx);
					dy_m_q   <= nre_pkg::mag33(dy);
					df_m_q   <= nre_pkg::mag33(df);
					ax_n_q   <= ax[32];
					ay_n_q   <= ay[32];
					dx_n_q   <= dx[32];
					dy_n_q   <= dy[32];
					df_n_q   <= df[32];
					e0_q     <= s_tdata[159:128];
					e1_q     <= s_tdata[255:224];
					single_q <= s_tuser;
					last_q   <= s_tlast;
				end
			end
			nre_pkg::ST_ACC: acc_q <= acc_next;
			nre_pkg::ST_POST: begin
				ovf_q <= acc_q[66:64] != 3'd0;
				case (op_q)
					nre_pkg::OP_DYY: den_q <= acc_q;
					nre_pkg::OP_DOTB: begin
						if (acc_q < 67'sd0) dist_q <= d0_q;
						else if (acc_q > den_q) dist_q <= d1_q;
					end
					nre_pkg::OP_CRSB: begin
						if (cmag[66:64] != 3'd0) dist_q <= nre_pkg::MAX32;
					end
					nre_pkg::OP_RADB: begin
						if (acc_q < 67'sd0) elev_q <= e0_q;
					end
					default: ;
				endcase
			end
			nre_pkg::ST_WAIT: begin
				if (rsp.done) begin
					case (op_q)
						nre_pkg::OP_AYY: d0_q <= root_sat;
						nre_pkg::OP_BYY: begin
							d1_q <= root_sat;
							if (degen) dist_q <= d0_q;
						end
						nre_pkg::OP_DYY:  seg_q <= root_sat;
						nre_pkg::OP_CRSB: dist_q <= div_sat;
						nre_pkg::OP_RADB: p_q <= rsp.res[31:0];
						nre_pkg::OP_PROD: elev_q <= elev_int;
						default: ;
					endcase
				end
			end
			nre_pkg::ST_FINISH: begin
				if (last_q && out_free) begin
					out_dist_q  <= best_dist_q;
					out_elev_q  <= best_elev_q;
					out_found_q <= have_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == nre_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_elev_q, out_dist_q};
	assign m_tuser  = out_found_q;

endmodule

// File: design/nre_checker.sv
// Port-level checker for the nearest ridge elevation core, with its bind.
module nre_port_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [255:0] s_tdata,
	input logic         s_tuser,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic         m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("core ready right after taking a ridge");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result transaction changed");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser)
		else $error("result without any ridge");

	a_no_burst: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result raised before the ridge was processed");

endmodule

bind nearest_ridge_elevation_core nre_port_checker u_nre_port_checker (.*);

// File: dv/nre_checker.sv
// Checker for the nearest ridge core: watches both channels, predicts results and compares.
module nre_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [255:0] s_tdata,
	input  logic         s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic         m_tuser,
	output int           errors,
	output int           pending,
	output int           checked
);

	localparam logic [32:0] TOL = 33'd66;
	localparam logic [31:0] SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] distance;
		logic [31:0] elev;
		logic        found;
	} nearest_t;

	nearest_t    nearest_q[$];
	logic [31:0] kept_dist;
	logic [31:0] kept_elev;
	logic        kept_valid;

	function automatic logic [31:0] root64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [32:0] abs33(logic signed [32:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] length_of(logic signed [32:0] a, logic signed [32:0] b);
		logic [64:0] ua;
		logic [64:0] ub;
		logic [64:0] s;
		ua = abs33(a);
		ub = abs33(b);
		s = ua * ua + ub * ub;
		return s[64] ? SAT : root64(s[63:0]);
	endfunction

	function automatic logic [31:0] along_elev(logic signed [31:0] e0, logic signed [31:0] e1,
			logic [31:0] d0, logic [31:0] distance, logic [31:0] seg);
		logic [63:0]        d0sq;
		logic [63:0]        dsq;
		logic [63:0]        p;
		logic [63:0]        q;
		logic signed [32:0] diff;
		logic signed [35:0] v;
		d0sq = 64'(d0) * 64'(d0);
		dsq = 64'(distance) * 64'(distance);
		if (dsq > d0sq) return e0;
		p = 64'(root64(d0sq - dsq));
		diff = 33'(e1) - 33'(e0);
		q = (p * 64'(abs33(diff))) / 64'((seg == 0) ? 32'd1 : seg);
		if (q > 64'h1_FFFF_FFFF) q = 64'h1_FFFF_FFFF;
		v = (diff < 0) ? 36'(e0) - $signed({3'b0, q[32:0]}) : 36'(e0) + $signed({3'b0, q[32:0]});
		if (v > 36'sd2147483647) v = 36'sd2147483647;
		if (v < -36'sd2147483648) v = -36'sd2147483648;
		return v[31:0];
	endfunction

	task automatic fold_ridge(logic [255:0] d, logic single, logic last);
		logic signed [32:0] ax, ay, bx, by, dx, dy;
		logic signed [66:0] wax, way, wdx, wdy, dot, den, crs;
		logic [31:0]        d0, d1, distance, seg, new_elev;
		logic [63:0]        quo;
		logic               at_end;
		nearest_t           r;
		ax = 33'($signed(d[31:0])) - 33'($signed(d[95:64]));
		ay = 33'($signed(d[63:32])) - 33'($signed(d[127:96]));
		bx = 33'($signed(d[31:0])) - 33'($signed(d[191:160]));
		by = 33'($signed(d[63:32])) - 33'($signed(d[223:192]));
		dx = 33'($signed(d[191:160])) - 33'($signed(d[95:64]));
		dy = 33'($signed(d[223:192])) - 33'($signed(d[127:96]));
		d0 = length_of(ax, ay);
		seg = 0;
		at_end = 1;
		if (single) begin
			if (!kept_valid || d0 < kept_dist) begin
				kept_dist = d0;
				kept_elev = d[159:128];
				kept_valid = 1;
			end
		end else begin
			d1 = length_of(bx, by);
			if (abs33(dx) < TOL && abs33(dy) < TOL) begin
				distance = d0;
			end else begin
				wax = ax; way = ay; wdx = dx; wdy = dy;
				den = wdx * wdx + wdy * wdy;
				dot = wax * wdx + way * wdy;
				seg = den[64] ? SAT : root64(den[63:0]);
				if (dot < 0) begin
					distance = d0;
				end else if (dot > den) begin
					distance = d1;
				end else begin
					crs = wax * wdy - way * wdx;
					if (crs < 0) crs = -crs;
					if (crs[64]) begin
						distance = SAT;
					end else begin
						quo = crs[63:0] / 64'((seg == 0) ? 32'd1 : seg);
						distance = (quo > 64'(SAT)) ? SAT : quo[31:0];
					end
					at_end = 0;
				end
			end
			if (!(kept_valid && kept_dist < distance)) begin
				if (at_end) begin
					if (d0 < d1) begin
						kept_dist = d0;
						kept_elev = d[159:128];
					end else begin
						kept_dist = d1;
						kept_elev = d[255:224];
					end
				end else begin
					new_elev = along_elev(d[159:128], d[255:224], d0, distance, seg);
					kept_dist = distance;
					kept_elev = new_elev;
				end
				kept_valid = 1;
			end
		end
		if (last) begin
			r.distance = kept_dist;
			r.elev = kept_elev;
			r.found = kept_valid;
			nearest_q.push_back(r);
			kept_dist = 0;
			kept_elev = 0;
			kept_valid = 0;
		end
	endtask

	task automatic report(string what, logic [31:0] want, logic [31:0] got);
		$display("MISMATCH %s: expected %h, got %h (result %0d)", what, want, got, checked);
		errors++;
	endtask

	initial begin
		errors = 0;
		checked = 0;
		kept_dist = 0;
		kept_elev = 0;
		kept_valid = 0;
	end

	always @(posedge clk) begin
		nearest_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) fold_ridge(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready) begin
				if (nearest_q.size() == 0) begin
					report("unexpected transaction", 0, m_tdata[31:0]);
				end else begin
					e = nearest_q.pop_front();
					if (m_tdata[31:0] !== e.distance)
						report("nearest_dist", e.distance, m_tdata[31:0]);
					if (m_tdata[63:32] !== e.elev) report("nearest_elev", e.elev, m_tdata[63:32]);
					if (m_tuser !== e.found) report("found", 32'(e.found), 32'(m_tuser));
				end
				checked++;
			end
		end
		pending = nearest_q.size();
	end

endmodule

// File: dv/tb_nearest_ridge_elevation_core.sv
// Testbench top: clock, reset, ridge stimulus, result stalls and verdict.
module tb_nearest_ridge_elevation_core;

	localparam int LIMIT = 3_000_000;
	localparam int RANDOM_RIDGES = 1650;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic         m_tuser;
	int           errors;
	int           pending;
	int           checked;
	int           cycles;
	int           sent;
	bit           calm_send;
	bit           calm_recv;

	nearest_ridge_elevation_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	nre_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// ready only changes at the rising edge, so its value here is what the next edge sees
	task automatic send_ridge(logic [31:0] px, logic [31:0] py, logic [31:0] x0, logic [31:0] y0,
			logic [31:0] e0, logic [31:0] x1, logic [31:0] y1, logic [31:0] e1,
			logic single, logic last);
		int gap;
		gap = draw_gap(calm_send);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {e1, y1, x1, e0, y0, x0, py, px};
		s_tuser <= single;
		s_tlast <= last;
		s_tvalid <= 1;
		while (!s_tready) @(negedge clk);
		@(negedge clk);
		sent++;
		if (sent % 120 == 0) calm_send = !calm_send && ($urandom_range(0, 2) == 0);
	endtask

	// coordinate near a center, with an occasional full-range or extreme value
	function automatic logic [31:0] near(logic [31:0] c);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) return $urandom;
		if (sel == 1) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return c + ($urandom >> $urandom_range(7, 28)) - ($urandom >> $urandom_range(7, 28));
	endfunction

	task automatic random_ridge(logic [31:0] px, logic [31:0] py, logic last);
		logic [31:0] x0, y0, x1, y1, e0, e1;
		int          shape;
		shape = $urandom_range(0, 9);
		x0 = near(px);
		y0 = near(py);
		x1 = near(px);
		y1 = near(py);
		e0 = ($urandom_range(0, 3) == 0) ? $urandom : $urandom >> 12;
		e1 = ($urandom_range(0, 3) == 0) ? $urandom : $urandom >> 12;
		if (shape == 0) begin
			x1 = x0 + $urandom_range(0, 130) - 65;
			y1 = y0 + $urandom_range(0, 130) - 65;
		end
		send_ridge(px, py, x0, y0, e0, x1, y1, e1, shape == 1, last);
	endtask

	initial begin
		logic [31:0] px, py;
		int          n, k;
		cycles = 0;
		sent = 0;
		calm_send = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		s_tlast = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: single points, extremes, degenerate, both end cases, interior, ties
		send_ridge(0, 0, 32'h0001_0000, 0, 32'h0005_0000, 0, 0, 0, 1, 1);
		send_ridge(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
		send_ridge(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 1);
		send_ridge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
		send_ridge(0, 0, 32'h0002_0000, 0, 32'h10, 32'h0002_0041, 32'h41, 32'h20, 0, 1);
		send_ridge(0, 0, 32'h0002_0000, 0, 32'h10, 32'h0002_0042, 0, 32'h20, 0, 1);
		send_ridge(0, 0, 32'h0001_0000, 0, 32'h100, 32'h0005_0000, 0, 32'h200, 0, 1);
		send_ridge(32'h0009_0000, 0, 32'h0001_0000, 0, 32'h100, 32'h0005_0000, 0, 32'h200, 0, 1);
		send_ridge(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 0, 32'hFFFF_0000,
			32'h0005_0000, 0, 32'h0007_0000, 0, 1);
		send_ridge(32'h0003_0000, 32'h0002_0000, 0, 32'h0004_0000, 32'h7FFF_FFFF,
			32'h0006_0000, 32'h0004_0000, 32'h8000_0000, 0, 0);
		send_ridge(32'h0003_0000, 32'h0002_0000, 0, 0, 32'h1234_0000,
			32'h0006_0000, 0, 32'h0000_1000, 0, 1);
		send_ridge(0, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h8000_0000,
			32'h0001_0000, 0, 32'h7FFF_FFFF, 0, 1);
		send_ridge(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
		send_ridge(0, 0, 32'h0001_0000, 0, 32'h11, 0, 0, 0, 1, 0);
		send_ridge(0, 0, 0, 32'h0001_0000, 32'h22, 0, 0, 0, 1, 1);
		send_ridge(5, 5, 5, 5, 32'h33, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h44, 0, 0);
		send_ridge(5, 5, 5, 5, 32'h55, 32'h8000_0000, 32'h8000_0000, 32'h66, 0, 1);
		send_ridge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);

		// random query points, each with a short run of ridges
		k = 0;
		while (k < RANDOM_RIDGES) begin
			px = ($urandom_range(0, 7) == 0) ? $urandom : $urandom >> $urandom_range(4, 16);
			py = ($urandom_range(0, 7) == 0) ? $urandom : $urandom >> $urandom_range(4, 16);
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) random_ridge(px, py, i == n - 1);
			k += n;
			if (k > RANDOM_RIDGES / 2 && k - n <= RANDOM_RIDGES / 2) begin
				s_tvalid <= 0;
				while (pending != 0) @(negedge clk);
			end
		end
		s_tvalid <= 0;
		s_tlast <= 0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);

		$display("%0d ridges sent, %0d nearest results checked", sent, checked);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		int stall;
		int taken;
		taken = 0;
		calm_recv = 0;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_gap(calm_recv);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1;
			while (!m_tvalid) @(negedge clk);
			@(posedge clk);
			taken++;
			if (taken % 40 == 0) calm_recv = !calm_recv;
		end
	end

endmodule

// File: filelist.f
design/nre_pkg.sv
design/nre_mul.sv
design/nre_iter.sv
design/nearest_ridge_elevation_core.sv
design/nre_checker.sv
dv/nre_checker.sv
dv/tb_nearest_ridge_elevation_core.sv
